@@ sv/mck_pkg.sv @@
// Shared types and constants for the Morse code keyer.
// Holds the transaction payload structs, timing struct and length calculation.
// No dependencies.
package mck_pkg;

   localparam int unsigned K_W       = 12;
   localparam int unsigned MARK_W    = 12;
   localparam int unsigned GAP_W     = 14;
   localparam int unsigned SPEED_W   = 8;
   localparam int unsigned CHAR_W    = 8;
   localparam int unsigned CSR_DW    = 32;
   localparam int unsigned CSR_AW    = 3;

   localparam logic [SPEED_W-1:0] SPEED_RESET = 8'd20;
   localparam logic [MARK_W-1:0]  MARK_MAX    = 12'd4095;
   localparam logic [GAP_W-1:0]   GAP_MAX     = 14'd16383;

   localparam logic ACT_TICK   = 1'b0;
   localparam logic ACT_SUBMIT = 1'b1;

   typedef struct packed {
      logic              action;
      logic [CHAR_W-1:0] char_code;
   } req_type;

   typedef struct packed {
      logic key_on;
      logic transmitting;
      logic submit_status;
      logic idle;
   } rsp_type;

   typedef struct packed {
      logic [MARK_W-1:0] dot_mark;
      logic [MARK_W-1:0] dash_mark;
      logic [GAP_W-1:0]  dot_gap;
      logic [GAP_W-1:0]  letter_gap;
      logic [GAP_W-1:0]  space_gap;
      logic [GAP_W-1:0]  unmapped_gap;
   } timing_type;

   function automatic timing_type lengths_calc(input logic [K_W-1:0] k);
      logic [16:0] k1;
      logic [16:0] k2;
      logic [16:0] k3;
      logic [16:0] k5;
      logic [16:0] k7;
      timing_type  t;
      k1 = 17'(k);
      k2 = k1 << 1;
      k3 = k2 + k1;
      k5 = (k1 << 2) + k1;
      k7 = (k1 << 3) - k1;
      t.dot_mark     = (k1 > 17'(MARK_MAX)) ? MARK_MAX : k1[MARK_W-1:0];
      t.dash_mark    = (k3 > 17'(MARK_MAX)) ? MARK_MAX : k3[MARK_W-1:0];
      t.dot_gap      = (k1 > 17'(GAP_MAX))  ? GAP_MAX  : k1[GAP_W-1:0];
      t.letter_gap   = (k2 > 17'(GAP_MAX))  ? GAP_MAX  : k2[GAP_W-1:0];
      t.space_gap    = (k7 > 17'(GAP_MAX))  ? GAP_MAX  : k7[GAP_W-1:0];
      t.unmapped_gap = (k5 > 17'(GAP_MAX))  ? GAP_MAX  : k5[GAP_W-1:0];
      return t;
   endfunction

endpackage

@@ sv/morse_code_keyer.sv @@
// Morse code keyer top level: speed register, length table and keyer core.
// Instantiates mck_timing and mck_core; uses mck_pkg.
//
// Each request transaction is either a 1 ms tick or a character submit; every
// request yields exactly one response transaction. One request is accepted per
// clock cycle unless rsp_ready stalls, and its response appears in the output
// register on the next cycle; the output register lets a new request enter
// while the previous response is being taken. The dot length DOT_BASE/speed_wpm
// is read from a 256-entry constant table when speed_wpm is written, and the
// dot, dash and gap lengths are held in registers from then on, so a write to
// speed_wpm takes effect next cycle. Reset leaves the keyer idle at 20 wpm.
module morse_code_keyer #(
   parameter int unsigned DOT_BASE = 1200
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  mck_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output mck_pkg::rsp_type           rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [mck_pkg::CSR_AW-1:0] paddr,
   input  logic [mck_pkg::CSR_DW-1:0] pwdata,
   output logic [mck_pkg::CSR_DW-1:0] prdata,
   output logic                       pready
);
   import mck_pkg::*;

   timing_type timing;

   mck_timing #(
      .DOT_BASE (DOT_BASE)
   ) u_timing (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .timing  (timing)
   );

   mck_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .timing    (timing)
   );

endmodule

@@ sv/mck_timing.sv @@
// Speed register with APB-style access and element length registers.
// Dot length comes from a constant table built at elaboration; uses mck_pkg.
module mck_timing #(
   parameter int unsigned DOT_BASE = 1200
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mck_pkg::CSR_AW-1:0]    paddr,
   input  logic [mck_pkg::CSR_DW-1:0]    pwdata,
   output logic [mck_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready,
   output mck_pkg::timing_type           timing
);
   import mck_pkg::*;

   localparam int unsigned ROM_DEPTH = 2 ** SPEED_W;
   localparam logic [K_W-1:0] RESET_K = K_W'(DOT_BASE / SPEED_RESET);

   logic [K_W-1:0]     dot_rom [ROM_DEPTH];
   logic [SPEED_W-1:0] speed_ff;
   timing_type         timing_ff;
   logic               wr_en;

   for (genvar i = 0; i < ROM_DEPTH; i++) begin : g_rom
      localparam int unsigned KVAL = DOT_BASE / ((i == 0) ? 1 : i);
      assign dot_rom[i] = K_W'(KVAL);
   end

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready && (paddr[CSR_AW-1] == 1'b0);
   assign prdata = (paddr[CSR_AW-1] == 1'b0) ? CSR_DW'(speed_ff) : '0;
   assign timing = timing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff  <= SPEED_RESET;
         timing_ff <= lengths_calc(RESET_K);
      end else if (wr_en) begin
         speed_ff  <= pwdata[SPEED_W-1:0];
         timing_ff <= lengths_calc(dot_rom[pwdata[SPEED_W-1:0]]);
      end
   end

endmodule

@@ sv/mck_core.sv @@
// Keyer state update and registered result stage.
// Takes element lengths from mck_timing; uses mck_pkg.
module mck_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mck_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output mck_pkg::rsp_type    rsp_data,
   input  mck_pkg::timing_type timing
);
   import mck_pkg::*;

   typedef enum logic [1:0] {PH_DONE, PH_INIT, PH_OUT, PH_NEXT} phase_type;
   typedef enum logic [1:0] {CH_END, CH_SPACE, CH_UNMAPPED, CH_PATTERN} kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  pat;
   } decode_type;

   localparam logic [7:0] CODE_END   = 8'd0;
   localparam logic [7:0] CODE_SPACE = 8'd32;
   localparam logic [7:0] CODE_CT    = 8'd1;
   localparam logic [7:0] CODE_AR    = 8'd3;
   localparam logic [7:0] CODE_VA    = 8'd4;
   localparam logic [7:0] CODE_AA    = 8'd8;
   localparam logic [7:0] CODE_BK    = 8'd16;
   localparam logic [7:0] CODE_BT    = 8'd22;
   localparam logic [7:0] CODE_KN    = 8'd23;
   localparam logic [7:0] CODE_AS    = 8'd27;
   localparam logic [7:0] GLYPH_LO   = 8'd44;
   localparam logic [7:0] GLYPH_HI   = 8'd90;
   localparam logic [7:0] LOWER_LO   = 8'd97;
   localparam logic [7:0] LOWER_HI   = 8'd122;
   localparam logic [7:0] CASE_DIFF  = 8'd32;
   localparam logic [7:0] LAST_ELEM  = 8'h80;

   localparam logic [7:0] GLYPH_ROM [47] = '{
      8'hCE, 8'h86, 8'h56, 8'h94,
      8'hFC, 8'h7C, 8'h3C, 8'h1C, 8'h0C, 8'h04, 8'h84, 8'hC4, 8'hE4, 8'hF4,
      8'hE2, 8'hAA, 8'h80, 8'h8C, 8'h80, 8'h32, 8'h80,
      8'h60, 8'h88, 8'hA8, 8'h90, 8'h40, 8'h28, 8'hD0, 8'h08, 8'h20, 8'h78,
      8'hB0, 8'h48, 8'hE0, 8'hA0, 8'hF0, 8'h68, 8'hD8, 8'h50, 8'h10, 8'hC0,
      8'h30, 8'h18, 8'h70, 8'h98, 8'hB8, 8'hC8
   };

   function automatic decode_type decode_char(input logic [7:0] c);
      logic [7:0] up;
      logic [7:0] idx;
      decode_type d;
      up    = ((c >= LOWER_LO) && (c <= LOWER_HI)) ? (c - CASE_DIFF) : c;
      idx   = up - GLYPH_LO;
      d.pat = 8'h00;
      if ((up < GLYPH_LO) || (up > GLYPH_HI)) begin
         d.kind = CH_UNMAPPED;
      end else begin
         d.kind = CH_PATTERN;
         d.pat  = GLYPH_ROM[idx[5:0]];
      end
      unique case (c)
         CODE_END: begin
            d.kind = CH_END;
         end
         CODE_SPACE: begin
            d.kind = CH_SPACE;
         end
         CODE_AR: begin
            d.kind = CH_PATTERN;
            d.pat  = 8'h54;
         end
         CODE_VA: begin
            d.kind = CH_PATTERN;
            d.pat  = 8'h16;
         end
         CODE_BT: begin
            d.kind = CH_PATTERN;
            d.pat  = 8'h8C;
         end
         CODE_BK: begin
            d.kind = CH_PATTERN;
            d.pat  = 8'h8B;
         end
         CODE_KN: begin
            d.kind = CH_PATTERN;
            d.pat  = 8'hB4;
         end
         CODE_AS: begin
            d.kind = CH_PATTERN;
            d.pat  = 8'h44;
         end
         CODE_AA: begin
            d.kind = CH_PATTERN;
            d.pat  = 8'h58;
         end
         CODE_CT: begin
            d.kind = CH_PATTERN;
            d.pat  = 8'hAC;
         end
         default: begin
         end
      endcase
      return d;
   endfunction

   phase_type          phase_ff, phase_in;
   logic [MARK_W-1:0]  mark_ff, mark_in;
   logic [GAP_W-1:0]   gap_ff, gap_in;
   logic [7:0]         shift_ff, shift_in;
   logic               key_ff, key_in;
   logic               tx_ff, tx_in;
   logic [CHAR_W-1:0]  held_char_ff, held_char_in;
   logic               held_valid_ff, held_valid_in;
   logic               busy;
   logic               accept;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   decode_type         dec;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign dec       = decode_char(held_char_ff);

   always_comb begin
      phase_in      = phase_ff;
      mark_in       = mark_ff;
      gap_in        = gap_ff;
      shift_in      = shift_ff;
      key_in        = key_ff;
      tx_in         = tx_ff;
      held_char_in  = held_char_ff;
      held_valid_in = held_valid_ff;
      busy          = 1'b0;
      if (req_data.action == ACT_SUBMIT) begin
         if (held_valid_ff) begin
            busy = 1'b1;
         end else begin
            held_char_in  = req_data.char_code;
            held_valid_in = 1'b1;
            if (phase_ff == PH_DONE) begin
               phase_in = PH_INIT;
            end
         end
      end else if (phase_ff != PH_DONE) begin
         if (mark_ff == '0) begin
            key_in = 1'b0;
            if (gap_ff != '0) begin
               gap_in = gap_ff - 1'b1;
            end
         end else begin
            mark_in = mark_ff - 1'b1;
         end
         if ((mark_in == '0) && (gap_in == '0)) begin
            unique case (phase_ff)
               PH_INIT: begin
                  if (held_valid_ff) begin
                     tx_in = 1'b1;
                     unique case (dec.kind)
                        CH_END: begin
                           tx_in         = 1'b0;
                           held_valid_in = 1'b0;
                           phase_in      = PH_DONE;
                        end
                        CH_SPACE: begin
                           gap_in   = timing.space_gap;
                           phase_in = PH_NEXT;
                        end
                        CH_UNMAPPED: begin
                           gap_in   = timing.unmapped_gap;
                           phase_in = PH_NEXT;
                        end
                        CH_PATTERN: begin
                           shift_in = dec.pat;
                           phase_in = PH_OUT;
                        end
                     endcase
                  end
               end
               PH_OUT: begin
                  if (shift_ff == LAST_ELEM) begin
                     gap_in   = timing.letter_gap;
                     phase_in = PH_NEXT;
                  end else begin
                     mark_in  = shift_ff[7] ? timing.dash_mark : timing.dot_mark;
                     key_in   = 1'b1;
                     shift_in = {shift_ff[6:0], 1'b0};
                     gap_in   = timing.dot_gap;
                  end
               end
               PH_NEXT: begin
                  held_valid_in = 1'b0;
                  phase_in      = PH_INIT;
               end
               PH_DONE: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_DONE;
         mark_ff       <= '0;
         gap_ff        <= '0;
         shift_ff      <= '0;
         key_ff        <= 1'b0;
         tx_ff         <= 1'b0;
         held_char_ff  <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_ff        <= '0;
      end else begin
         if (accept) begin
            phase_ff             <= phase_in;
            mark_ff              <= mark_in;
            gap_ff               <= gap_in;
            shift_ff             <= shift_in;
            key_ff               <= key_in;
            tx_ff                <= tx_in;
            held_char_ff         <= held_char_in;
            held_valid_ff        <= held_valid_in;
            rsp_ff.key_on        <= key_in;
            rsp_ff.transmitting  <= tx_in;
            rsp_ff.submit_status <= busy;
            rsp_ff.idle          <= (phase_in == PH_DONE);
            rsp_valid_ff         <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_key_needs_tx: assert property (@(posedge clock) disable iff (reset)
      key_ff |-> tx_ff)
      else $error("key active without transmitter enable");

   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE) |-> !held_valid_ff)
      else $error("holding register full while done");

   a_mark_in_out: assert property (@(posedge clock) disable iff (reset)
      (mark_ff != '0) |-> (phase_ff == PH_OUT))
      else $error("mark counting outside element phase");

   a_busy_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.submit_status) |-> held_valid_ff)
      else $error("busy reported with empty holding register");

endmodule
